// ===== rtl/ssg_pkg.sv =====
// Package for the staggered surface gradient stencil.
// Holds cell and line buffer entry types, widths, register indexes and the pseudo-surface function.
`default_nettype none
package ssg_pkg;

   localparam int MaxCols  = 1024;
   localparam int ColW     = $clog2(MaxCols);
   localparam int WidthW   = 11;
   localparam int RowW     = 16;
   localparam int InvW     = 41;
   localparam int DiffW    = 34;
   localparam int GradW    = 32;
   localparam int OutColW  = 10;

   localparam logic [1:0] RegMethod = 2'd0;
   localparam logic [1:0] RegWidth  = 2'd1;
   localparam logic [1:0] RegInvDx  = 2'd2;
   localparam logic [1:0] RegInvDy  = 2'd3;

   typedef struct packed {
      logic signed [31:0] surf;
      logic signed [31:0] bed;
      logic               icefree;
   } cell_type;

   typedef struct packed {
      cell_type upper;
      cell_type lower;
   } lbuf_entry_type;

   typedef struct packed {
      logic [ColW-1:0]    col;
      logic [RowW-1:0]    row;
   } meta_type;

   // surface of neighbor nb as seen from reference point rf
   function automatic logic signed [31:0] pseudo_surf(cell_type nb, cell_type rf, logic mode);
      logic signed [31:0] res;
      res = nb.surf;
      if (mode && ((nb.icefree && (nb.bed > rf.surf)) || (rf.icefree && (rf.bed > nb.surf))))
         res = rf.surf;
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ssg_linebuf.sv =====
// Dual line buffer memory: one entry per column holds the two previous rows.
// Read-before-write memory with one cycle read latency and write-to-read forwarding; uses ssg_pkg.
`default_nettype none
module ssg_linebuf
   import ssg_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            rd_en,
   input  wire logic [ColW-1:0] rd_addr,
   input  wire logic            wr_en,
   input  wire logic [ColW-1:0] wr_addr,
   input  wire lbuf_entry_type  wr_data,
   output      lbuf_entry_type  rd_data
);

   lbuf_entry_type mem [MaxCols];
   lbuf_entry_type mem_q_ff;
   lbuf_entry_type fwd_data_ff;
   logic           fwd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff    <= mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : mem_q_ff;

endmodule
`default_nettype wire

// ===== rtl/ssg_scale.sv =====
// One gradient lane: difference times reciprocal spacing, rounded and saturated to Q24.
// Three stages: split multiply, round and saturate, sign restore; uses ssg_pkg.
`default_nettype none
module ssg_scale
   import ssg_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    en,
   input  wire logic signed [DiffW-1:0] diff,
   input  wire logic [InvW-1:0]         inv,
   input  wire logic                    shift26,
   output      logic [GradW-1:0]        grad
);

   localparam int LoW = 21;
   localparam int HiW = InvW - LoW;
   localparam int FullW = DiffW + InvW;

   logic [DiffW-1:0]     mag;
   logic [DiffW+LoW-1:0] p_lo_ff;
   logic [DiffW+HiW-1:0] p_hi_ff;
   logic                 neg_a_ff;
   logic                 neg_b_ff;
   logic [FullW-1:0]     full;
   logic [FullW:0]       rnd;
   logic [FullW-24-1:0]  quo;
   logic [FullW-24-1:0]  limit;
   logic [GradW-1:0]     mag_ff;
   logic [GradW-1:0]     grad_ff;

   assign mag = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);

   assign full  = FullW'(p_lo_ff) + {p_hi_ff, {LoW{1'b0}}};
   assign rnd   = (FullW+1)'(full) + (shift26 ? ((FullW+1)'(1) << 25) : ((FullW+1)'(1) << 23));
   assign quo   = shift26 ? (FullW-24)'(rnd[FullW:26]) : rnd[FullW-1:24];
   assign limit = neg_a_ff ? (FullW-24)'(33'h0_8000_0000) : (FullW-24)'(33'h0_7FFF_FFFF);

   always_ff @(posedge clock) begin
      if (en) begin
         p_lo_ff  <= (DiffW+LoW)'(mag) * (DiffW+LoW)'(inv[LoW-1:0]);
         p_hi_ff  <= (DiffW+HiW)'(mag) * (DiffW+HiW)'(inv[InvW-1:LoW]);
         neg_a_ff <= diff[DiffW-1];
         neg_b_ff <= neg_a_ff;
         mag_ff   <= (quo > limit) ? GradW'(limit) : GradW'(quo);
         grad_ff  <= neg_b_ff ? GradW'(-mag_ff) : mag_ff;
      end
   end

   assign grad = grad_ff;

endmodule
`default_nettype wire

// ===== rtl/staggered_surface_gradient_stencil.sv =====
// Staggered surface gradient stencil. Takes one grid point per clock in raster order while
// req_stall is low, and gives the east and north face surface gradients for every interior
// center (column and row >= 2 of the incoming point) via input, window, difference and scale
// registers. The line buffer read-modify-write per point sets that rate. No clearing pass.
`default_nettype none
module staggered_surface_gradient_stencil
   import ssg_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic signed [31:0]  req_surface_elev,
   input  wire logic signed [31:0]  req_bed_elev,
   input  wire logic signed [31:0]  req_thickness,
   input  wire logic                req_start_of_grid,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic signed [31:0]  rsp_east_grad_x,
   output      logic signed [31:0]  rsp_east_grad_y,
   output      logic signed [31:0]  rsp_north_grad_x,
   output      logic signed [31:0]  rsp_north_grad_y,
   output      logic [OutColW-1:0]  rsp_center_col,
   output      logic [RowW-1:0]     rsp_center_row,
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [InvW-1:0]     csr_data
);

   logic             method_ff;
   logic [WidthW-1:0] width_ff;
   logic [InvW-1:0]  inv_dx_ff;
   logic [InvW-1:0]  inv_dy_ff;

   logic [ColW-1:0]  col_ff, col_in;
   logic [RowW-1:0]  row_ff, row_in;
   logic [ColW-1:0]  cur_c;
   logic [RowW-1:0]  cur_r;
   logic [WidthW-1:0] eff_w;

   logic             adv, accept;
   logic [6:1]       vld_ff;
   meta_type         meta_ff [1:6];
   cell_type         s1_cell_ff;
   logic             s1_prod_ff;

   lbuf_entry_type   rd_data, wr_data;
   cell_type         win_ff [3][3];

   logic signed [31:0]       h_e, h_n, h_s, h_w;
   logic signed [DiffW-1:0]  d_ex_ff, d_ey_ff, d_nx_ff, d_ny_ff;
   logic [GradW-1:0]         g_ex, g_ey, g_nx, g_ny;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff <= 1'b0;
         width_ff  <= WidthW'(MaxCols);
         inv_dx_ff <= InvW'(64'd1073741824);
         inv_dy_ff <= InvW'(64'd1073741824);
      end else if (csr_valid) begin
         case (csr_index)
            RegMethod: method_ff <= csr_data[0];
            RegWidth:  width_ff  <= csr_data[WidthW-1:0];
            RegInvDx:  inv_dx_ff <= csr_data;
            RegInvDy:  inv_dy_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign adv       = !vld_ff[6] || !rsp_stall;
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   always_comb begin
      eff_w = width_ff;
      if (width_ff < WidthW'(3))
         eff_w = WidthW'(3);
      if (width_ff > WidthW'(MaxCols))
         eff_w = WidthW'(MaxCols);
      cur_c = req_start_of_grid ? '0 : col_ff;
      cur_r = req_start_of_grid ? '0 : row_ff;
      if ((WidthW'(cur_c) + WidthW'(1)) >= eff_w) begin
         col_in = '0;
         row_in = (cur_r == {RowW{1'b1}}) ? cur_r : cur_r + RowW'(1);
      end else begin
         col_in = cur_c + ColW'(1);
         row_in = cur_r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         vld_ff <= '0;
      end else if (adv) begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         vld_ff[1] <= accept;
         vld_ff[2] <= vld_ff[1] && s1_prod_ff;
         vld_ff[6:3] <= vld_ff[5:2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cell_ff.surf    <= req_surface_elev;
         s1_cell_ff.bed     <= req_bed_elev;
         s1_cell_ff.icefree <= (req_thickness <= 32'sd0);
         s1_prod_ff         <= (cur_c >= ColW'(2)) && (cur_r >= RowW'(2));
         meta_ff[1].col     <= cur_c - ColW'(1);
         meta_ff[1].row     <= cur_r - RowW'(1);
         for (int i = 2; i <= 6; i++)
            meta_ff[i] <= meta_ff[i-1];
      end
   end

   assign wr_data.upper = rd_data.lower;
   assign wr_data.lower = s1_cell_ff;

   ssg_linebuf u_linebuf (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (cur_c),
      .wr_en   (adv && vld_ff[1]),
      .wr_addr (meta_ff[1].col + ColW'(1)),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // window rows: 0 south, 1 mid, 2 north; columns: 0 west, 1 center, 2 east
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++)
               win_ff[k][j] <= '0;
      end else if (adv && vld_ff[1]) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= win_ff[k][2];
         end
         win_ff[0][2] <= rd_data.upper;
         win_ff[1][2] <= rd_data.lower;
         win_ff[2][2] <= s1_cell_ff;
      end
   end

   assign h_e = pseudo_surf(win_ff[1][2], win_ff[1][1], method_ff);
   assign h_n = pseudo_surf(win_ff[2][1], win_ff[1][1], method_ff);
   assign h_s = pseudo_surf(win_ff[0][1], win_ff[1][1], method_ff);
   assign h_w = pseudo_surf(win_ff[1][0], win_ff[1][1], method_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ex_ff <= DiffW'(h_e) - DiffW'(win_ff[1][1].surf);
         d_ny_ff <= DiffW'(h_n) - DiffW'(win_ff[1][1].surf);
         d_ey_ff <= DiffW'(pseudo_surf(win_ff[2][2], win_ff[1][2], method_ff)) + DiffW'(h_n)
                  - DiffW'(pseudo_surf(win_ff[0][2], win_ff[1][2], method_ff)) - DiffW'(h_s);
         d_nx_ff <= DiffW'(pseudo_surf(win_ff[2][2], win_ff[2][1], method_ff)) + DiffW'(h_e)
                  - DiffW'(pseudo_surf(win_ff[2][0], win_ff[2][1], method_ff)) - DiffW'(h_w);
      end
   end

   ssg_scale u_ex (.clock(clock), .en(adv), .diff(d_ex_ff), .inv(inv_dx_ff), .shift26(1'b0),
                   .grad(g_ex));
   ssg_scale u_ey (.clock(clock), .en(adv), .diff(d_ey_ff), .inv(inv_dy_ff), .shift26(1'b1),
                   .grad(g_ey));
   ssg_scale u_nx (.clock(clock), .en(adv), .diff(d_nx_ff), .inv(inv_dx_ff), .shift26(1'b1),
                   .grad(g_nx));
   ssg_scale u_ny (.clock(clock), .en(adv), .diff(d_ny_ff), .inv(inv_dy_ff), .shift26(1'b0),
                   .grad(g_ny));

   assign rsp_valid        = vld_ff[6];
   assign rsp_east_grad_x  = g_ex;
   assign rsp_east_grad_y  = g_ey;
   assign rsp_north_grad_x = g_nx;
   assign rsp_north_grad_y = g_ny;
   assign rsp_center_col   = OutColW'(meta_ff[6].col);
   assign rsp_center_row   = meta_ff[6].row;

endmodule
`default_nettype wire

// ===== rtl/ssg_checker.sv =====
// Port-level checker for the staggered surface gradient stencil, bound to the top level.
// Depends on ssg_pkg for widths.
`default_nettype none
module ssg_checker
   import ssg_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic signed [31:0]  rsp_east_grad_x,
   input wire logic [OutColW-1:0]  rsp_center_col,
   input wire logic [RowW-1:0]     rsp_center_row
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_east_grad_x)
                                 && $stable(rsp_center_col))
      else $error("stalled result beat changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_center_col != '0 && rsp_center_col <= OutColW'(1022))
      else $error("center column out of range");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_center_row != '0)
      else $error("center row zero");

endmodule

bind staggered_surface_gradient_stencil ssg_checker u_ssg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_east_grad_x (rsp_east_grad_x),
   .rsp_center_col  (rsp_center_col),
   .rsp_center_row  (rsp_center_row)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for staggered_surface_gradient_stencil: raster grids go in over a valid/stall
// channel, and face gradients coming out are checked against an in-bench line-buffer predictor.
// Depends on ssg_pkg and the stencil RTL only.
`timescale 1ns / 1ps
module tb;
   import ssg_pkg::*;

   typedef struct {
      logic signed [31:0] surf;
      logic signed [31:0] bed;
      logic signed [31:0] thick;
      logic               sog;
   } point_type;

   typedef struct {
      logic signed [31:0] ex;
      logic signed [31:0] ey;
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic [9:0]         col;
      logic [15:0]        row;
   } grad_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_surface_elev = '0;
   logic signed [31:0] req_bed_elev = '0;
   logic signed [31:0] req_thickness = '0;
   logic               req_start_of_grid = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_east_grad_x, rsp_east_grad_y, rsp_north_grad_x, rsp_north_grad_y;
   logic [OutColW-1:0] rsp_center_col;
   logic [RowW-1:0]    rsp_center_row;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = RegMethod;
   logic [InvW-1:0]    csr_data = '0;

   staggered_surface_gradient_stencil u_top (.*);

   always #4 clock = ~clock;

   // predictor state and register copies
   cell_type    upper_row [MaxCols];
   cell_type    lower_row [MaxCols];
   cell_type    win [3][3];
   int          col_cnt, row_cnt;
   logic        method_q;
   logic [10:0] width_q;
   logic [40:0] inv_dx_q, inv_dy_q;

   point_type points_pending[$];
   grad_type  gradients_due[$];
   point_type cur;
   int        errors = 0;
   bit        no_idle = 0;
   int        gap_left = 0;
   int        stall_left = 0;

   function automatic int idle_draw();
      return no_idle ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0);
   endfunction

   function automatic longint surf_seen(cell_type nb, cell_type rf);
      if (method_q && ((nb.icefree && nb.bed > rf.surf) || (rf.icefree && rf.bed > nb.surf)))
         return longint'(rf.surf);
      return longint'(nb.surf);
   endfunction

   function automatic logic [31:0] scaled(longint d, logic [40:0] inv, int k);
      logic [127:0] m;
      logic [127:0] lim;
      bit           neg;
      neg = d < 0;
      m = neg ? 128'(-d) : 128'(d);
      m = (m * {87'd0, inv} + (128'd1 << (k - 1))) >> k;
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (m > lim) m = lim;
      return neg ? -m[31:0] : m[31:0];
   endfunction

   task automatic stencil_advance(point_type p);
      cell_type nw;
      grad_type g;
      int       eff, c, r;
      longint   hE, hN, hS, hW, ey, nx, ps;
      eff = width_q < 3 ? 3 : (width_q > MaxCols ? MaxCols : width_q);
      if (p.sog) begin
         col_cnt = 0;
         row_cnt = 0;
      end
      c = col_cnt;
      r = row_cnt;
      nw.surf = p.surf;
      nw.bed = p.bed;
      nw.icefree = p.thick <= 0;
      for (int k = 0; k < 3; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2] = upper_row[c];
      win[1][2] = lower_row[c];
      win[2][2] = nw;
      upper_row[c] = lower_row[c];
      lower_row[c] = nw;
      if (c >= 2 && r >= 2) begin
         ps = longint'(win[1][1].surf);
         hE = surf_seen(win[1][2], win[1][1]);
         hN = surf_seen(win[2][1], win[1][1]);
         hS = surf_seen(win[0][1], win[1][1]);
         hW = surf_seen(win[1][0], win[1][1]);
         ey = surf_seen(win[2][2], win[1][2]) + hN - surf_seen(win[0][2], win[1][2]) - hS;
         nx = surf_seen(win[2][2], win[2][1]) + hE - surf_seen(win[2][0], win[2][1]) - hW;
         g.ex = scaled(hE - ps, inv_dx_q, 24);
         g.ey = scaled(ey, inv_dy_q, 26);
         g.nx = scaled(nx, inv_dx_q, 26);
         g.ny = scaled(hN - ps, inv_dy_q, 24);
         g.col = 10'(c - 1);
         g.row = 16'(r - 1);
         gradients_due.push_back(g);
      end
      if (col_cnt + 1 >= eff) begin
         col_cnt = 0;
         if (row_cnt < 65535) row_cnt++;
      end else begin
         col_cnt++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            stencil_advance(cur);
            gap_left = idle_draw();
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (points_pending.size() > 0) begin
            cur = points_pending.pop_front();
            req_valid <= 1'b1;
            req_surface_elev <= cur.surf;
            req_bed_elev <= cur.bed;
            req_thickness <= cur.thick;
            req_start_of_grid <= cur.sog;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
         errors++;
      end
   endfunction

   // monitor
   always @(posedge clock) begin
      grad_type g;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (gradients_due.size() == 0) begin
               $display("%0t: unexpected gradient beat at col %0d row %0d", $realtime,
                        rsp_center_col, rsp_center_row);
               errors++;
            end else begin
               g = gradients_due.pop_front();
               check_field("east_grad_x", g.ex, rsp_east_grad_x);
               check_field("east_grad_y", g.ey, rsp_east_grad_y);
               check_field("north_grad_x", g.nx, rsp_north_grad_x);
               check_field("north_grad_y", g.ny, rsp_north_grad_y);
               check_field("center_col", 32'(g.col), 32'(rsp_center_col));
               check_field("center_row", 32'(g.row), 32'(rsp_center_row));
            end
            stall_left = idle_draw();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [40:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         RegMethod: method_q = val[0];
         RegWidth:  width_q = val[10:0];
         RegInvDx:  inv_dx_q = val;
         default:   inv_dy_q = val;
      endcase
   endtask

   task automatic drain();
      while (points_pending.size() > 0 || req_valid || gradients_due.size() > 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic point_type rand_point(int base, bit wild);
      point_type p;
      p.sog = 1'b0;
      if (wild || $urandom_range(0, 9) == 0) begin
         p.surf = $urandom;
         p.bed = $urandom;
      end else begin
         p.surf = base + $urandom_range(0, 4000) - 2000;
         p.bed = p.surf + $urandom_range(0, 6000) - 3000;
      end
      case ($urandom_range(0, 3))
         0: p.thick = 0;
         1: p.thick = -$urandom_range(1, 500);
         2: p.thick = $urandom_range(1, 500);
         default: p.thick = $urandom;
      endcase
      return p;
   endfunction

   task automatic push_grid(int eff, int rows, bit noisy);
      point_type p;
      int        base;
      bit        wild;
      base = $urandom_range(0, 1) ? $urandom_range(0, 100000) : $urandom;
      wild = $urandom_range(0, 4) == 0;
      for (int i = 0; i < eff * rows; i++) begin
         p = rand_point(base, wild);
         p.sog = (i == 0) || (noisy && $urandom_range(0, 60) == 0);
         points_pending.push_back(p);
      end
   endtask

   function automatic logic [40:0] rand_inv();
      case ($urandom_range(0, 5))
         0: return 41'd1;
         1: return 41'h100_0000_0000;
         2: return 41'h1ff_ffff_ffff;
         3: return 41'h4000_0000;
         4: return 41'($urandom_range(1, 1 << 20));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      point_type p;
      int        fed, eff, w;
      method_q = 1'b0;
      width_q = 11'd1024;
      inv_dx_q = 41'h4000_0000;
      inv_dy_q = 41'h4000_0000;
      col_cnt = 0;
      row_cnt = 0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) win[i][j] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme surfaces with the top-bit and all-ones spacing reciprocals, plain differences
      write_reg(RegWidth, 41'd3);
      write_reg(RegInvDx, 41'h100_0000_0000);
      write_reg(RegInvDy, 41'h1ff_ffff_ffff);
      for (int i = 0; i < 12; i++) begin
         p.surf = (i % 2) ? 32'sh7fff_ffff : 32'sh8000_0000;
         p.bed = (i % 3) ? 32'sh8000_0000 : 32'sh7fff_ffff;
         p.thick = (i % 4) ? 32'sh8000_0000 : 32'sh7fff_ffff;
         p.sog = i == 0;
         points_pending.push_back(p);
      end
      drain();
      // directed: pseudo-surface substitution on ice-free points with high beds
      write_reg(RegMethod, 41'd1);
      write_reg(RegInvDx, 41'd1);
      write_reg(RegInvDy, 41'h4000_0000);
      for (int i = 0; i < 12; i++) begin
         p.surf = 1000 * (i % 5);
         p.bed = (i % 2) ? 6000 : -500;
         p.thick = (i % 3 == 0) ? 0 : 100;
         p.sog = i == 0;
         points_pending.push_back(p);
      end
      drain();

      fed = 0;
      while (fed < 700) begin
         no_idle = $urandom_range(0, 4) == 0;
         write_reg(RegMethod, 41'($urandom_range(0, 1)));
         w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 120) : $urandom_range(0, 24);
         write_reg(RegWidth, 41'(w));
         write_reg(RegInvDx, rand_inv());
         write_reg(RegInvDy, rand_inv());
         eff = w < 3 ? 3 : (w > MaxCols ? MaxCols : w);
         if (eff > 64) begin
            push_grid(eff, 3, 0);
            fed += 3 * eff;
         end else begin
            push_grid(eff, 60 / eff + 3, 1);
            fed += eff * (60 / eff + 3);
         end
         drain();
      end

      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
